FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by the queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on rising clock, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/fsq_pkg.sv
// package: types and constants of the single-precision square root core
`timescale 1ns / 1ps
`default_nettype none
package fsq_pkg;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned RootSteps = 26;
  localparam int unsigned RemW = 52;
  localparam logic [31:0] CanonNan = 32'h7FC00001;
  localparam logic [31:0] NegZero = 32'h80000000;
  localparam logic [31:0] PosInf = 32'h7F800000;
  localparam logic [9:0] ExpBias = 10'd127;
  localparam logic [9:0] OutBias = 10'd126;

  // classified operand handed from front to back
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic [23:0] mant;
    logic        odd;
    logic [7:0]  expo;
  } fsq_item_t;
endpackage
`default_nettype wire

FILE: hw/rtl/float32_square_root_core.sv
// top level: single-precision square root core with stream ports
// Single-precision square root, round half up, canonical NaN 0x7FC00001 for NaN and negative
// nonzero operands. One operand is taken every cycle unless the queue is full. An operand
// passes through the front register, the queue, a load register, 26 root stages of one result
// bit each, and the rounding register, which drives out_tvalid. A queue of QDEPTH entries lets
// the front keep taking operands while the output is held, until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module float32_square_root_core
  import fsq_pkg::*;
#(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // operand_bits
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // root_bits
);
  fsq_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_ready;

  fsq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_bits(in_tdata),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  fsq_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item)
  );

  fsq_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_bits(out_tdata)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/fsq_front.sv
// front: accepts operands, sorts out special values, normalizes subnormals
`timescale 1ns / 1ps
`default_nettype none
module fsq_front
  import fsq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_bits,
  output logic             item_valid,
  input  wire logic        item_ready,
  output fsq_item_t        item
);
  logic      vld_r, vld_nxt;
  fsq_item_t item_r, item_nxt;
  logic [4:0] lead;
  logic [9:0] ebias;
  logic [9:0] half;
  logic [7:0] efield;
  logic [22:0] frac;

  assign in_ready = !vld_r || item_ready;
  assign efield = in_bits[30:23];
  assign frac = in_bits[22:0];

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) lead = 5'(i);
    end
  end

  always_comb begin
    item_nxt = '0;
    item_nxt.mant = {1'b1, frac};
    ebias = {2'b0, efield};
    if (efield == 8'd0) begin
      item_nxt.mant = 24'({1'b0, frac} << (5'd23 - lead));
      ebias = 10'd1 - {5'b0, (5'd23 - lead)};
    end
    // exponent parity flips since the bias is odd
    item_nxt.odd = ~ebias[0];
    half = 10'($signed(ebias - ExpBias) >>> 1) + OutBias;
    item_nxt.expo = half[7:0];
    if (in_bits[31]) begin
      item_nxt.special = 1'b1;
      item_nxt.spec_val = (in_bits == NegZero) ? NegZero : CanonNan;
    end else if (efield == 8'hFF) begin
      item_nxt.special = 1'b1;
      item_nxt.spec_val = (in_bits == PosInf) ? PosInf : CanonNan;
    end else if (efield == 8'd0 && frac == 23'd0) begin
      item_nxt.special = 1'b1;
      item_nxt.spec_val = 32'd0;
    end
  end

  assign vld_nxt = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = vld_r;
  assign item = item_r;
endmodule
`default_nettype wire

FILE: hw/rtl/fsq_queue.sv
// queue: short fifo between the front and the root pipeline
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fsq_queue
  import fsq_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  fsq_item_t push_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output fsq_item_t pop_item
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  fsq_item_t mem [DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign push_ready = (cnt_r != CntW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = mem[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) wr_nxt = (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop) rd_nxt = (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_r <= CntW'(DEPTH), "queue count over depth")
  `ASSERT_CLK(a_cnt_track, clk, rst_n, (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1,
              "queue count missed a push")
  `ASSERT_NEVER(a_ptr_gap, clk, rst_n, cnt_r == '0 && wr_r != rd_r, "empty queue with pointer gap")
endmodule
`default_nettype wire

FILE: hw/rtl/fsq_back.sv
// back: digit-by-digit root pipeline, one result bit per stage, then rounding
`timescale 1ns / 1ps
`default_nettype none
module fsq_back
  import fsq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  fsq_item_t        item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_bits
);
  logic             vld_r [RootSteps+1];
  logic [RemW-1:0]  rem_r [RootSteps+1];
  logic [RemW-1:0]  res_r [RootSteps+1];
  fsq_item_t        itm_r [RootSteps+1];
  logic             ov_r;
  logic [31:0]      obits_r;
  logic             en;
  logic [24:0]      rnd;

  // whole pipeline moves together unless the result waits
  assign en = !ov_r || out_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm_r[0] <= item;
      rem_r[0] <= ({(RemW-24)'(0), item.mant} << (25 + {5'b0, item.odd}));
      res_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_step
    localparam logic [RemW-1:0] Bit = RemW'(1) << (2 * (RootSteps - 1 - k));
    logic [RemW-1:0] trial;
    assign trial = res_r[k] + Bit;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm_r[k+1] <= itm_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + Bit;
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  assign rnd = 25'(res_r[RootSteps][24:0] + 25'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[RootSteps];
    end
  end

  // rounding carry may run into the exponent field
  always_ff @(posedge clk) begin
    if (en) begin
      obits_r <= itm_r[RootSteps].special ? itm_r[RootSteps].spec_val :
                 {1'b0, itm_r[RootSteps].expo, 23'd0} + {8'd0, rnd[24:1]};
    end
  end

  assign out_valid = ov_r;
  assign out_bits = obits_r;
endmodule
`default_nettype wire

FILE: tb/sv/fsq_root_checker.sv
// checker: predicts square roots of transferred operands and compares the results
`timescale 1ns / 1ps
module fsq_root_checker
  import fsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          err_count,
  output int          pending
);
  logic [31:0] expected_roots[$];

  // floor square root of a radicand below 2^52, one result bit per step
  function automatic logic [31:0] isqrt50(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 50;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] root_of_normal(logic [31:0] mant, int e);
    logic [31:0] r;
    int odd_e;
    int half;
    logic [31:0] expo;
    odd_e = e & 1;
    r = isqrt50((64'(mant) << odd_e) << 25);
    half = (e - odd_e) / 2;
    expo = 32'(half + 126) << 23;
    return expo + ((r + 32'd1) >> 1);
  endfunction

  function automatic logic [31:0] predict_root(logic [31:0] u);
    logic [7:0] ef;
    logic [31:0] m;
    int shift;
    ef = u[30:23];
    m = {9'd0, u[22:0]};
    shift = 0;
    if (u[31]) return (u == NegZero) ? NegZero : CanonNan;
    if (ef == 8'hFF) return (u == PosInf) ? PosInf : CanonNan;
    if (ef != 0) return root_of_normal(m | 32'h0080_0000, int'(ef) - 127);
    if (m == 0) return 32'd0;
    // subnormal: bring leading one up to the implicit position
    while (m[23] == 1'b0) begin
      m = m << 1;
      shift++;
    end
    return root_of_normal(m, -126 - shift);
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      err_count <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_roots.push_back(predict_root(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_roots.size() == 0) begin
          if (err_count < 10) $display("unexpected result transfer %h", out_tdata);
          err_count <= err_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want !== out_tdata) begin
            if (err_count < 10) $display("root_bits mismatch: expected %h got %h", want, out_tdata);
            err_count <= err_count + 1;
          end
        end
      end
      pending <= expected_roots.size();
    end
  end
endmodule

FILE: tb/sv/tb_float32_square_root_core.sv
// testbench top: operand stimulus, output back-pressure and verdict
`timescale 1ns / 1ps
module tb_float32_square_root_core;
  import fsq_pkg::*;
  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [31:0] in_tdata, out_tdata;
  int err_count, pending;
  int send_idle, recv_idle;
  bit hold_recv;

  float32_square_root_core i_dut (.*);
  fsq_root_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver back-pressure, with an optional long hold-off
  initial begin
    int hold_cnt;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        hold_cnt = 0;
        out_tready <= 0;
        while (hold_cnt < 200) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_recv = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'h0;
      3: v[30:23] = $urandom_range(1) ? 8'h01 : 8'hFE;
      default: v[31] = ($urandom_range(7) == 0);
    endcase
    return v;
  endfunction

  task automatic send(logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  logic [31:0] directed[] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001, 32'h007F_FFFF,
    32'h8000_0001, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h4000_0000,
    32'h4080_0000, 32'h3F7F_FFFF, 32'hBF80_0000, 32'h0040_0000, 32'h5555_5555,
    32'h2AAA_AAAA};

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_recv = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[k]) send(directed[k]);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 83; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 83; end
        3: begin send_idle = 30; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; hold_recv = 1; end
      endcase
      for (int n = 0; n < 100; n++) send(random_operand());
      in_tvalid <= 0;
      // in phase 1 only, the sender pauses until all results are back
      if (ph == 1) while (pending != 0) @(posedge clk);
    end
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fsq_pkg.sv
hw/rtl/fsq_front.sv
hw/rtl/fsq_queue.sv
hw/rtl/fsq_back.sv
hw/rtl/float32_square_root_core.sv
tb/sv/fsq_root_checker.sv
tb/sv/tb_float32_square_root_core.sv
